// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hdl/wts_pkg.sv -----
package wts_pkg;

   // Largest texture edge in texels.
   localparam int TEX_DIM_MAX = 64;

   // Derived sizes.
   localparam int DIM_W       = $clog2(TEX_DIM_MAX + 1);
   localparam int TIW         = $clog2(TEX_DIM_MAX);
   localparam int FACE_WORDS  = TEX_DIM_MAX * TEX_DIM_MAX;
   localparam int STORE_WORDS = 4 * FACE_WORDS;
   localparam int ADDR_W      = $clog2(STORE_WORDS);

   // Fixed field widths.
   localparam int FACE_W  = 2;
   localparam int INDEX_W = 12;
   localparam int COLOR_W = 32;
   localparam int FRAC_W  = 16;
   localparam int LINE_W  = 16;
   localparam int COORD_W = FRAC_W + 1;
   localparam int CFG_DIM_W  = 7;
   localparam int PRESENT_W  = 4;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;
   localparam int REQ_DATA_W = 112;

   // The quotient saturates at 2**QUO_W, which always exceeds the last row.
   localparam int QUO_W = DIM_W;
   localparam int NUM_W = LINE_W + DIM_W;

   // Register indexes.
   localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
   localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
   localparam logic [1:0] REG_PRESENT    = 2'd2;

   // Request kinds.
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   // Wall faces.
   localparam logic [FACE_W-1:0] FACE_NORTH = 2'd0;
   localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd1;
   localparam logic [FACE_W-1:0] FACE_EAST  = 2'd2;
   localparam logic [FACE_W-1:0] FACE_WEST  = 2'd3;

   // Color returned for a face whose texture is not loaded.
   localparam logic [COLOR_W-1:0] FALLBACK_COLOR [4] = '{
      32'h00ff0000, 32'h00ffff00, 32'h000000ff, 32'h00ffffff
   };

   // One pipeline slot; each stage fills in the fields it is responsible for.
   typedef struct packed {
      logic                sample;
      logic                wr_ok;
      logic [FACE_W-1:0]   face;
      logic                miss;
      logic [INDEX_W-1:0]  tex_index;
      logic [COLOR_W-1:0]  color;
      logic [DIM_W-1:0]    col;
      logic [NUM_W-1:0]    rem;
      logic [LINE_W-1:0]   wh;
      logic [QUO_W-1:0]    quo;
      logic                sat;
      logic [TIW-1:0]      row;
      logic [ADDR_W-1:0]   addr;
   } stage_type;

   // A size register of zero or above the maximum is pulled into range.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > TEX_DIM_MAX) begin
         r = DIM_W'(TEX_DIM_MAX);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

// ----- hdl/wall_texel_sampler.sv -----
// Wall texel sampler for a raycaster. Requests enter on req_ at one per clock and run
// through a fixed pipeline: operand capture with the column and row products, a
// restoring divider that resolves one quotient bit per stage (seven stages), a row
// clamp, address generation, the texel store read and an output register. A new
// request can be accepted every clock; the pipeline stalls only when rsp_tready holds
// a result back and every stage is full. Load requests write the texel store in
// pipeline order and give no response, so a sample that follows a load always sees it.
// The texel store is not cleared after reset; texels that were never loaded read as
// arbitrary data. Configuration (csr_) must be written while no request is in flight.
module wall_texel_sampler (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // From bit 0: face[1:0], texel_index[13:2], texel_color[45:14], impact_x_frac[61:46],
   // impact_y_frac[77:62], screen_line[93:78], wall_height[109:94], zero fill.
   input  logic [wts_pkg::REQ_DATA_W-1:0]    req_tdata,
   // From bit 0: mode.
   input  logic                              req_tuser,
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // From bit 0: pixel_color[31:0].
   output logic [wts_pkg::COLOR_W-1:0]       rsp_tdata,
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wts_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [wts_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [wts_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import wts_pkg::*;

   `include "assert_macros.svh"

   // Stage numbering.
   localparam int ROW_ST  = QUO_W + 1;
   localparam int ADDR_ST = QUO_W + 2;
   localparam int MEM_ST  = QUO_W + 3;
   localparam int PROD_W  = COORD_W + DIM_W;

   // Configuration registers.
   logic [CFG_DIM_W-1:0] tex_width_ff;
   logic [CFG_DIM_W-1:0] tex_height_ff;
   logic [PRESENT_W-1:0] present_ff;
   logic [1:0]           csr_index;
   logic                 csr_wr;
   logic [DIM_W-1:0]     w_eff;
   logic [DIM_W-1:0]     h_eff;

   // Pipeline.
   stage_type            pipe_ff [0:MEM_ST];
   stage_type            pipe_in [0:MEM_ST];
   logic [MEM_ST:0]      pipe_v_ff;
   logic [MEM_ST:0]      pipe_v_in;
   logic [MEM_ST:0]      en;
   logic                 en_out;

   // Request fields.
   logic                 req_mode;
   logic [FACE_W-1:0]    req_face;
   logic [INDEX_W-1:0]   req_index;
   logic [COLOR_W-1:0]   req_color;
   logic [FRAC_W-1:0]    req_x_frac;
   logic [FRAC_W-1:0]    req_y_frac;
   logic [LINE_W-1:0]    req_line;
   logic [LINE_W-1:0]    req_wh;

   // Texel store and output.
   logic [COLOR_W-1:0]   store [STORE_WORDS];
   logic [COLOR_W-1:0]   rdata_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [COLOR_W-1:0]   rsp_color_ff;
   logic [COLOR_W-1:0]   rsp_color_in;

   // Register port: always ready, written on the access phase.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= CFG_DIM_W'(64);
         tex_height_ff <= CFG_DIM_W'(64);
         present_ff    <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            REG_TEX_WIDTH:  tex_width_ff  <= csr_pwdata[CFG_DIM_W-1:0];
            REG_TEX_HEIGHT: tex_height_ff <= csr_pwdata[CFG_DIM_W-1:0];
            REG_PRESENT:    present_ff    <= csr_pwdata[PRESENT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TEX_WIDTH:  csr_prdata = CSR_DW'(tex_width_ff);
         REG_TEX_HEIGHT: csr_prdata = CSR_DW'(tex_height_ff);
         REG_PRESENT:    csr_prdata = CSR_DW'(present_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign w_eff = clamp_dim(tex_width_ff);
   assign h_eff = clamp_dim(tex_height_ff);

   // Unpack the request.
   assign req_mode   = req_tuser;
   assign req_face   = req_tdata[1:0];
   assign req_index  = req_tdata[13:2];
   assign req_color  = req_tdata[45:14];
   assign req_x_frac = req_tdata[61:46];
   assign req_y_frac = req_tdata[77:62];
   assign req_line   = req_tdata[93:78];
   assign req_wh     = req_tdata[109:94];

   // Stage enables: a stage loads when it is empty or its occupant moves on.
   always_comb begin
      en_out     = !rsp_valid_ff || rsp_tready;
      en[MEM_ST] = !pipe_v_ff[MEM_ST] || en_out;
      for (int i = MEM_ST - 1; i >= 0; i--) begin
         en[i] = !pipe_v_ff[i] || en[i + 1];
      end
   end

   assign req_tready = en[0];

   // Capture stage: pick and mirror the fraction, form the column and row products.
   always_comb begin
      logic [FRAC_W-1:0]  frac;
      logic               mirror;
      logic [COORD_W-1:0] coord;
      logic [PROD_W-1:0]  col_prod;
      stage_type          nx;
      frac   = (req_face == FACE_NORTH || req_face == FACE_SOUTH) ? req_x_frac : req_y_frac;
      mirror = (req_face == FACE_NORTH || req_face == FACE_EAST);
      coord  = mirror ? (COORD_W'(1) << FRAC_W) - COORD_W'(frac) : COORD_W'(frac);
      col_prod = PROD_W'(coord) * PROD_W'(w_eff);
      nx           = '0;
      nx.sample    = (req_mode == MODE_SAMPLE);
      nx.face      = req_face;
      nx.miss      = !present_ff[req_face];
      nx.tex_index = req_index;
      nx.color     = req_color;
      nx.col       = col_prod[FRAC_W +: DIM_W];
      nx.rem       = NUM_W'(req_line) * NUM_W'(h_eff);
      nx.wh        = req_wh;
      pipe_in[0]   = nx;
      pipe_v_in[0] = req_tvalid;
   end

   // Divider stages, one quotient bit each, most significant first. The first stage
   // also clamps the column and flags a quotient too large for the bits kept.
   for (genvar j = 1; j <= QUO_W; j++) begin : g_div
      always_comb begin
         logic [NUM_W-1:0] trial;
         stage_type        nx;
         nx    = pipe_ff[j - 1];
         trial = NUM_W'(nx.wh) << (QUO_W - j);
         if (j == 1) begin
            nx.sat = (nx.rem >= (NUM_W'(nx.wh) << QUO_W));
            if (nx.col > w_eff - DIM_W'(1)) begin
               nx.col = w_eff - DIM_W'(1);
            end
         end
         if (nx.rem >= trial) begin
            nx.rem             = nx.rem - trial;
            nx.quo[QUO_W - j]  = 1'b1;
         end
         pipe_in[j]   = nx;
         pipe_v_in[j] = pipe_v_ff[j - 1];
      end
   end

   // Row clamp to the last texel row.
   always_comb begin
      logic [DIM_W-1:0] h_last;
      stage_type        nx;
      nx     = pipe_ff[ROW_ST - 1];
      h_last = h_eff - DIM_W'(1);
      if (nx.sat || nx.quo > h_last) begin
         nx.row = TIW'(h_last);
      end else begin
         nx.row = TIW'(nx.quo);
      end
      pipe_in[ROW_ST]   = nx;
      pipe_v_in[ROW_ST] = pipe_v_ff[ROW_ST - 1];
   end

   // Address generation for both reads and writes.
   always_comb begin
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] offs;
      stage_type         nx;
      nx   = pipe_ff[ADDR_ST - 1];
      base = ADDR_W'(nx.face) * ADDR_W'(FACE_WORDS);
      if (nx.sample) begin
         offs = ADDR_W'(nx.row) * ADDR_W'(w_eff) + ADDR_W'(nx.col);
      end else begin
         offs = ADDR_W'(nx.tex_index);
      end
      nx.wr_ok = (32'(nx.tex_index) < FACE_WORDS);
      nx.addr  = base + offs;
      pipe_in[ADDR_ST]   = nx;
      pipe_v_in[ADDR_ST] = pipe_v_ff[ADDR_ST - 1];
   end

   // Loads end at the store; only samples go on.
   assign pipe_in[MEM_ST]   = pipe_ff[ADDR_ST];
   assign pipe_v_in[MEM_ST] = pipe_v_ff[ADDR_ST] && pipe_ff[ADDR_ST].sample;

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff <= '0;
      end else begin
         for (int i = 0; i <= MEM_ST; i++) begin
            if (en[i]) begin
               pipe_v_ff[i] <= pipe_v_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= MEM_ST; i++) begin
         if (en[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // Texel store: one access per clock while the read stage can advance, in request order.
   always_ff @(posedge clock) begin
      if (en[MEM_ST]) begin
         if (pipe_v_ff[ADDR_ST] && !pipe_ff[ADDR_ST].sample && pipe_ff[ADDR_ST].wr_ok) begin
            store[pipe_ff[ADDR_ST].addr] <= pipe_ff[ADDR_ST].color;
         end
         rdata_ff <= store[pipe_ff[ADDR_ST].addr];
      end
   end

   // Output register with the fallback color for faces without a texture.
   assign rsp_valid_in = pipe_v_ff[MEM_ST];
   assign rsp_color_in = pipe_ff[MEM_ST].miss ? FALLBACK_COLOR[pipe_ff[MEM_ST].face] : rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_color_ff <= rsp_color_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_color_ff;

   // A load must never reach the read-data stage.
   `ASSERT_IMPLY(a_no_load_at_read, clock, reset, pipe_v_ff[MEM_ST], pipe_ff[MEM_ST].sample, "load request reached the read stage")
   // Without saturation the divider must leave a remainder below the divisor.
   `ASSERT_IMPLY(a_div_remainder, clock, reset, pipe_v_ff[QUO_W] && pipe_ff[QUO_W].sample && !pipe_ff[QUO_W].sat, pipe_ff[QUO_W].rem < NUM_W'(pipe_ff[QUO_W].wh), "divider remainder not below divisor")
   // Read data must hold while the output stalls.
   `ASSERT_NEXT(a_read_held, clock, reset, pipe_v_ff[MEM_ST] && !en_out, $stable(rdata_ff), "texel read data changed during a stall")

endmodule
